// File: src/rcw_pkg.sv
// Package for the RTO estimator and congestion window block.
// Holds the item structs, register indexes, controller states and the
// command and status structs shared by the controller and datapath.
package rcw_pkg;

	// One input item: a transport event.
	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] rtt_sample;
		logic [15:0] remote_window;
		logic        fast_resent;
		logic        loss_seen;
		logic [15:0] in_flight;
	} in_item_t;

	// One result item: the current timer and window values.
	typedef struct packed {
		logic [15:0] rto_now;
		logic [15:0] cwnd_now;
		logic [15:0] threshold_now;
	} out_item_t;

	// Event codes carried in the mode field.
	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_ACK    = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_INTERVAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO           = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTO           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_RESEND_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESHOLD     = 3'd5;

	// Divider geometry: the segment size squared over the byte increment.
	localparam int DIV_STEPS = 28;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Reset values of the estimator and window state.
	localparam logic [15:0] RTO_RESET    = 16'd200;
	localparam logic [15:0] THRESH_RESET = 16'd2;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SAMPLE_UPD,
		ST_SAMPLE_RTO,
		ST_ACK_CHECK,
		ST_ACK_MUL_SQ,
		ST_ACK_DIV_START,
		ST_ACK_DIV_WAIT,
		ST_ACK_INCR,
		ST_ACK_MUL_WIN,
		ST_ACK_GROW,
		ST_FLUSH_FAST,
		ST_FLUSH_MUL,
		ST_FLUSH_INCR,
		ST_FLUSH_LOSS,
		ST_DONE
	} ctrl_state_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_SQ,
		MUL_WIN,
		MUL_FAST
	} mul_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_in;
		logic     srtt_upd;
		logic     rto_upd;
		logic     ack_check;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     incr_add;
		logic     win_grow;
		logic     fast_cut;
		logic     incr_from_prod;
		logic     loss_cut;
		logic     load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       ack_stop;
		logic       ack_slow;
		logic       fast_cut;
		logic       div_done;
		logic       out_busy;
	} dp_status_t;

endpackage

// File: src/rcw_div.sv
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for the congestion avoidance increment; uses rcw_pkg.
module rcw_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rcw_pkg::DIV_STEPS-1:0] dividend,
	input  logic [31:0]                   divisor,
	output logic [rcw_pkg::DIV_STEPS-1:0] quotient,
	output logic                          done
);

	logic [31:0]                   rem_q;
	logic [rcw_pkg::DIV_STEPS-1:0] quo_q;
	logic [rcw_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [32:0]                   shifted;
	logic [32:0]                   diff;
	logic                          fits;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		shifted = {rem_q, quo_q[rcw_pkg::DIV_STEPS-1]};
		diff    = shifted - {1'b0, divisor};
		fits    = shifted >= {1'b0, divisor};
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == rcw_pkg::DIV_CNT_W'(rcw_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[rcw_pkg::DIV_STEPS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: src/rcw_ctrl.sv
// Controller state machine of the RTO and congestion window block.
// Sequences the datapath through one event; uses rcw_pkg.
module rcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rcw_pkg::dp_status_t status,
	output rcw_pkg::ctrl_cmd_t  cmd
);

	rcw_pkg::ctrl_state_t state_q;
	rcw_pkg::ctrl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = rcw_pkg::MUL_NONE;
		in_ready    = 1'b0;
		case (state_q)
			rcw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = rcw_pkg::ST_DISPATCH;
				end
			end
			rcw_pkg::ST_DISPATCH: begin
				case (status.mode)
					rcw_pkg::MODE_SAMPLE: state_d = rcw_pkg::ST_SAMPLE_UPD;
					rcw_pkg::MODE_ACK:    state_d = rcw_pkg::ST_ACK_CHECK;
					rcw_pkg::MODE_FLUSH: begin
						state_d = status.fast_cut ? rcw_pkg::ST_FLUSH_FAST
							: rcw_pkg::ST_FLUSH_LOSS;
					end
					default: state_d = rcw_pkg::ST_DONE;
				endcase
			end
			rcw_pkg::ST_SAMPLE_UPD: begin
				cmd.srtt_upd = 1'b1;
				state_d      = rcw_pkg::ST_SAMPLE_RTO;
			end
			rcw_pkg::ST_SAMPLE_RTO: begin
				cmd.rto_upd = 1'b1;
				state_d     = rcw_pkg::ST_DONE;
			end
			rcw_pkg::ST_ACK_CHECK: begin
				cmd.ack_check = 1'b1;
				if (status.ack_stop || status.ack_slow) begin
					state_d = rcw_pkg::ST_DONE;
				end else begin
					state_d = rcw_pkg::ST_ACK_MUL_SQ;
				end
			end
			rcw_pkg::ST_ACK_MUL_SQ: begin
				cmd.mul_sel = rcw_pkg::MUL_SQ;
				state_d     = rcw_pkg::ST_ACK_DIV_START;
			end
			rcw_pkg::ST_ACK_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = rcw_pkg::ST_ACK_DIV_WAIT;
			end
			rcw_pkg::ST_ACK_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = rcw_pkg::ST_ACK_INCR;
				end
			end
			rcw_pkg::ST_ACK_INCR: begin
				cmd.incr_add = 1'b1;
				state_d      = rcw_pkg::ST_ACK_MUL_WIN;
			end
			rcw_pkg::ST_ACK_MUL_WIN: begin
				cmd.mul_sel = rcw_pkg::MUL_WIN;
				state_d     = rcw_pkg::ST_ACK_GROW;
			end
			rcw_pkg::ST_ACK_GROW: begin
				cmd.win_grow = 1'b1;
				state_d      = rcw_pkg::ST_DONE;
			end
			rcw_pkg::ST_FLUSH_FAST: begin
				cmd.fast_cut = 1'b1;
				state_d      = rcw_pkg::ST_FLUSH_MUL;
			end
			rcw_pkg::ST_FLUSH_MUL: begin
				cmd.mul_sel = rcw_pkg::MUL_FAST;
				state_d     = rcw_pkg::ST_FLUSH_INCR;
			end
			rcw_pkg::ST_FLUSH_INCR: begin
				cmd.incr_from_prod = 1'b1;
				state_d            = rcw_pkg::ST_FLUSH_LOSS;
			end
			rcw_pkg::ST_FLUSH_LOSS: begin
				cmd.loss_cut = 1'b1;
				state_d      = rcw_pkg::ST_DONE;
			end
			rcw_pkg::ST_DONE: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = rcw_pkg::ST_IDLE;
				end
			end
			default: state_d = rcw_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: src/rcw_dp.sv
// Datapath of the RTO and congestion window block: configuration, estimator
// and window state, shared multiplier, divider and output register.
// Uses rcw_pkg and rcw_div.
module rcw_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcw_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  rcw_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rcw_pkg::out_item_t                  out_item,
	input  rcw_pkg::ctrl_cmd_t                  cmd,
	output rcw_pkg::dp_status_t                 status
);

	// Configuration registers.
	logic [12:0] flush_interval_q;
	logic [15:0] min_rto_q;
	logic [15:0] max_rto_q;
	logic [13:0] segment_size_q;
	logic [7:0]  fast_resend_count_q;
	logic [15:0] min_threshold_q;

	// Estimator and window state.
	logic [23:0] srtt_q;
	logic [23:0] var_q;
	logic [15:0] rto_q;
	logic [15:0] cwnd_q;
	logic [15:0] ssthresh_q;
	logic [31:0] incr_q;

	// Latched event, product and result.
	rcw_pkg::in_item_t  in_q;
	rcw_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic [30:0]        prod_q;

	// Combinational values.
	logic [23:0] delta;
	logic [25:0] var3;
	logic [26:0] var_sum;
	logic [26:0] srtt7;
	logic [26:0] srtt_sum;
	logic [23:0] srtt_new;
	logic [23:0] var_new;
	logic [25:0] var4;
	logic [25:0] rto_term;
	logic [26:0] rto_raw;
	logic [26:0] rto_lo;
	logic [26:0] rto_hi;
	logic [32:0] slow_sum;
	logic [31:0] incr_slow;
	logic [31:0] incr_floor;
	logic [27:0] quo_eff;
	logic [28:0] avoid_add;
	logic [32:0] avoid_sum;
	logic [31:0] incr_avoid;
	logic [15:0] fast_half;
	logic [15:0] fast_thresh;
	logic [16:0] fast_sum;
	logic [15:0] fast_cwnd;
	logic [15:0] loss_half;
	logic [15:0] loss_thresh;
	logic [16:0] mul_a;
	logic [13:0] mul_b;
	logic [30:0] mul_p;
	logic [27:0] div_quo;
	logic        div_done;

	// RTT sample: smoothed RTT, variance, and the clamped RTO.
	always_comb begin
		delta    = (in_q.rtt_sample >= srtt_q) ? in_q.rtt_sample - srtt_q
			: srtt_q - in_q.rtt_sample;
		var3     = 26'({var_q, 1'b0}) + 26'(var_q);
		var_sum  = 27'(var3) + 27'(delta);
		srtt7    = 27'({srtt_q, 3'b000}) - 27'(srtt_q);
		srtt_sum = srtt7 + 27'(in_q.rtt_sample);
		if (srtt_q == '0) begin
			srtt_new = in_q.rtt_sample;
			var_new  = in_q.rtt_sample >> 1;
		end else begin
			var_new  = var_sum[25:2];
			srtt_new = (srtt_sum[26:3] == '0) ? 24'd1 : srtt_sum[26:3];
		end
		var4     = {var_q, 2'b00};
		rto_term = (var4 > 26'(flush_interval_q)) ? var4 : 26'(flush_interval_q);
		rto_raw  = 27'(srtt_q) + 27'(rto_term);
		rto_lo   = (rto_raw < 27'(min_rto_q)) ? 27'(min_rto_q) : rto_raw;
		rto_hi   = (rto_lo > 27'(max_rto_q)) ? 27'(max_rto_q) : rto_lo;
	end

	// Acknowledgment: slow start and congestion avoidance increments.
	always_comb begin
		slow_sum   = {1'b0, incr_q} + 33'(segment_size_q);
		incr_slow  = slow_sum[32] ? '1 : slow_sum[31:0];
		incr_floor = (incr_q < 32'(segment_size_q)) ? 32'(segment_size_q) : incr_q;
		quo_eff    = (incr_q == '0) ? '0 : div_quo;
		avoid_add  = 29'(quo_eff) + 29'(segment_size_q >> 4);
		avoid_sum  = {1'b0, incr_q} + 33'(avoid_add);
		incr_avoid = avoid_sum[32] ? '1 : avoid_sum[31:0];
	end

	// Flush: fast resend cut and loss cut.
	always_comb begin
		fast_half   = in_q.in_flight >> 1;
		fast_thresh = (fast_half > min_threshold_q) ? fast_half : min_threshold_q;
		fast_sum    = 17'(fast_thresh) + 17'(fast_resend_count_q);
		fast_cwnd   = fast_sum[16] ? '1 : fast_sum[15:0];
		loss_half   = cwnd_q >> 1;
		loss_thresh = (loss_half > min_threshold_q) ? loss_half : min_threshold_q;
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (cmd.mul_sel)
			rcw_pkg::MUL_SQ: begin
				mul_a = 17'(segment_size_q);
				mul_b = segment_size_q;
			end
			rcw_pkg::MUL_WIN: begin
				mul_a = 17'(cwnd_q) + 17'd1;
				mul_b = segment_size_q;
			end
			rcw_pkg::MUL_FAST: begin
				mul_a = 17'(cwnd_q);
				mul_b = segment_size_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 31'(mul_a) * 31'(mul_b);
	end

	// Divider for the segment size squared over the byte increment.
	rcw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q[27:0]),
		.divisor  (incr_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_interval_q    <= 13'd100;
			min_rto_q           <= 16'd100;
			max_rto_q           <= 16'd60000;
			segment_size_q      <= 14'd1376;
			fast_resend_count_q <= 8'd0;
			min_threshold_q     <= 16'd2;
		end else if (cfg_write) begin
			case (cfg_index)
				rcw_pkg::CFG_FLUSH_INTERVAL:    flush_interval_q    <= cfg_data[12:0];
				rcw_pkg::CFG_MIN_RTO:           min_rto_q           <= cfg_data;
				rcw_pkg::CFG_MAX_RTO:           max_rto_q           <= cfg_data;
				rcw_pkg::CFG_SEGMENT_SIZE:      segment_size_q      <= cfg_data[13:0];
				rcw_pkg::CFG_FAST_RESEND_COUNT: fast_resend_count_q <= cfg_data[7:0];
				rcw_pkg::CFG_MIN_THRESHOLD:     min_threshold_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Estimator and window state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q     <= '0;
			var_q      <= '0;
			rto_q      <= rcw_pkg::RTO_RESET;
			cwnd_q     <= '0;
			ssthresh_q <= rcw_pkg::THRESH_RESET;
			incr_q     <= '0;
		end else begin
			if (cmd.srtt_upd) begin
				srtt_q <= srtt_new;
				var_q  <= var_new;
			end
			if (cmd.rto_upd) begin
				rto_q <= rto_hi[15:0];
			end
			if (cmd.ack_check && !status.ack_stop) begin
				if (status.ack_slow) begin
					cwnd_q <= cwnd_q + 16'd1;
					incr_q <= incr_slow;
				end else begin
					incr_q <= incr_floor;
				end
			end
			if (cmd.incr_add) begin
				incr_q <= incr_avoid;
			end
			if (cmd.win_grow && (32'(prod_q) <= incr_q)) begin
				cwnd_q <= cwnd_q + 16'd1;
			end
			if (cmd.fast_cut) begin
				ssthresh_q <= fast_thresh;
				cwnd_q     <= fast_cwnd;
			end
			if (cmd.incr_from_prod) begin
				incr_q <= 32'(prod_q);
			end
			if (cmd.loss_cut) begin
				if (in_q.loss_seen) begin
					ssthresh_q <= loss_thresh;
					cwnd_q     <= 16'd1;
					incr_q     <= 32'(segment_size_q);
				end else if (cwnd_q == '0) begin
					cwnd_q <= 16'd1;
					incr_q <= 32'(segment_size_q);
				end
			end
		end
	end

	// Event latch, multiplier product register and output item register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_item;
		end
		if (cmd.mul_sel != rcw_pkg::MUL_NONE) begin
			prod_q <= mul_p;
		end
		if (cmd.load_out) begin
			out_q.rto_now       <= rto_q;
			out_q.cwnd_now      <= cwnd_q;
			out_q.threshold_now <= ssthresh_q;
		end
	end

	// Output item valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Status back to the controller.
	always_comb begin
		status.mode     = in_q.mode;
		status.ack_stop = cwnd_q >= in_q.remote_window;
		status.ack_slow = cwnd_q < ssthresh_q;
		status.fast_cut = in_q.fast_resent && (fast_resend_count_q != '0);
		status.div_done = div_done;
		status.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: src/rto_and_congestion_window.sv
// RTO estimator and AIMD congestion window. Each input item is one transport
// event (RTT sample, acknowledgment progress, or flush outcome) and yields one
// result item with the current RTO, congestion window and slow-start threshold.
// Items are handled one at a time. An RTT sample updates the smoothed RTT and
// variance, then the RTO; a flush outcome applies the fast resend cut if one
// is due, then the loss cut or window floor; an acknowledgment ends after the
// check in slow start or at the peer limit, and in congestion avoidance waits
// on the 28-step restoring divider; an unused mode code goes to the result.
// The controller is back in idle at the edge that presents the result, so the
// next item can be accepted in the cycle after. A finished result sits in an
// output register, so it may wait for the consumer while the next item is in
// progress; if it is still waiting when the next result is ready, the
// controller holds in its last state and the input is not ready. Configuration
// registers are written through a plain write port and should only be changed
// while the block is idle.
module rto_and_congestion_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rcw_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rcw_pkg::out_item_t             out_item,
	input  logic                           cfg_write,
	input  logic [rcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcw_pkg::CFG_DATA_W-1:0] cfg_data
);

	rcw_pkg::ctrl_cmd_t  cmd;
	rcw_pkg::dp_status_t status;

	// Sequencing of each event.
	rcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// State, arithmetic and output register.
	rcw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// File: tb/tb_rto_and_congestion_window.sv
// Self-checking testbench for rto_and_congestion_window: drives transport events,
// predicts the RTO, window and threshold for each one and compares every result.
// Depends on rcw_pkg and the rto_and_congestion_window RTL.
module tb_rto_and_congestion_window;
	timeunit 1ns;
	timeprecision 1ps;

	// Mode code that the block must ignore.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_LEN = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int EXP_DEPTH = 64;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	rcw_pkg::in_item_t              in_item = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	rcw_pkg::out_item_t             out_item;
	logic                           cfg_write = 1'b0;
	logic [rcw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rcw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Mirror of the configuration registers, at their reset values.
	logic [12:0] cf_flush_ival = 13'd100;
	logic [15:0] cf_min_rto = 16'd100;
	logic [15:0] cf_max_rto = 16'd60000;
	logic [13:0] cf_seg = 14'd1376;
	logic [7:0]  cf_fast_cnt = 8'd0;
	logic [15:0] cf_min_thresh = 16'd2;

	// Mirror of the estimator and window state, at reset values.
	logic [23:0] est_srtt = '0;
	logic [23:0] est_rttvar = '0;
	logic [15:0] est_rto = 16'd200;
	logic [15:0] est_cwnd = '0;
	logic [15:0] est_ssthresh = 16'd2;
	logic [31:0] est_incr = '0;
	logic [15:0] est_peer = 16'd128;

	// Ring of predicted results waiting for the block's output.
	rcw_pkg::out_item_t exp_buf[EXP_DEPTH];
	logic [5:0]  exp_head = '0;
	logic [5:0]  exp_tail = '0;
	int unsigned exp_count = 0;

	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned settings_written = 0;
	int unsigned mode_seen[4] = '{0, 0, 0, 0};
	int unsigned quiet_cycles = 0;
	int unsigned peer_hint = 128;
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;

	rto_and_congestion_window u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Smoothed RTT and variance update, then the clamped RTO.
	function automatic void take_rtt_sample(input logic [23:0] rtt);
		logic [63:0] r, s, v, delta, term, rto;
		r = 64'(rtt);
		if (est_srtt == '0) begin
			est_srtt = rtt;
			est_rttvar = rtt >> 1;
		end else begin
			s = 64'(est_srtt);
			v = 64'(est_rttvar);
			delta = (r >= s) ? r - s : s - r;
			v = (3 * v + delta) / 4;
			s = (7 * s + r) / 8;
			est_rttvar = v[23:0];
			est_srtt = (s < 1) ? 24'd1 : s[23:0];
		end
		term = 64'(est_rttvar);
		term = term * 4;
		if (term < 64'(cf_flush_ival))
			term = 64'(cf_flush_ival);
		rto = term + 64'(est_srtt);
		if (rto < 64'(cf_min_rto))
			rto = 64'(cf_min_rto);
		if (rto > 64'(cf_max_rto))
			rto = 64'(cf_max_rto);
		est_rto = rto[15:0];
	endfunction

	// Window growth on acknowledgment progress: slow start or byte-counted avoidance.
	function automatic void take_ack(input logic [15:0] rwnd);
		logic [63:0] mss, incr, q, cw;
		mss = 64'(cf_seg);
		est_peer = rwnd;
		if (est_cwnd < est_peer) begin
			if (est_cwnd < est_ssthresh) begin
				est_cwnd = est_cwnd + 16'd1;
				est_incr = sat_add(est_incr, mss[31:0]);
			end else begin
				incr = 64'(est_incr);
				if (incr < mss)
					incr = mss;
				q = (incr != 0) ? (mss * mss) / incr : 64'd0;
				q = q + mss / 16;
				est_incr = sat_add(incr[31:0], q[31:0]);
				cw = 64'(est_cwnd);
				if ((cw + 1) * mss <= 64'(est_incr))
					est_cwnd = est_cwnd + 16'd1;
			end
			if (est_cwnd > est_peer) begin
				est_cwnd = est_peer;
				q = 64'(est_peer) * mss;
				est_incr = q[31:0];
			end
		end
	endfunction

	// Fast-resend cut, loss cut, then the floor of one segment.
	function automatic void take_flush(input logic fast, input logic loss,
			input logic [15:0] inflight);
		logic [31:0] half, w;
		if (fast && cf_fast_cnt != '0) begin
			half = 32'(inflight >> 1);
			est_ssthresh = (half > 32'(cf_min_thresh)) ? half[15:0] : cf_min_thresh;
			w = 32'(est_ssthresh) + 32'(cf_fast_cnt);
			est_cwnd = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
			est_incr = 32'(est_cwnd) * 32'(cf_seg);
		end
		if (loss) begin
			half = 32'(est_cwnd >> 1);
			est_ssthresh = (half > 32'(cf_min_thresh)) ? half[15:0] : cf_min_thresh;
			est_cwnd = 16'd1;
			est_incr = 32'(cf_seg);
		end
		if (est_cwnd == '0) begin
			est_cwnd = 16'd1;
			est_incr = 32'(cf_seg);
		end
	endfunction

	function automatic rcw_pkg::out_item_t predict_timers(input rcw_pkg::in_item_t ev);
		rcw_pkg::out_item_t res;
		case (ev.mode)
			rcw_pkg::MODE_SAMPLE: take_rtt_sample(ev.rtt_sample);
			rcw_pkg::MODE_ACK:    take_ack(ev.remote_window);
			rcw_pkg::MODE_FLUSH:  take_flush(ev.fast_resent, ev.loss_seen, ev.in_flight);
			default: ;
		endcase
		res.rto_now = est_rto;
		res.cwnd_now = est_cwnd;
		res.threshold_now = est_ssthresh;
		return res;
	endfunction

	function automatic rcw_pkg::in_item_t make_event(input logic [1:0] mode,
			input logic [23:0] rtt, input logic [15:0] rwnd, input logic fast,
			input logic loss, input logic [15:0] flight);
		rcw_pkg::in_item_t ev;
		ev.mode = mode;
		ev.rtt_sample = rtt;
		ev.remote_window = rwnd;
		ev.fast_resent = fast;
		ev.loss_seen = loss;
		ev.in_flight = flight;
		return ev;
	endfunction

	// Mostly plausible traffic around a peer window that changes now and then, plus noise.
	function automatic rcw_pkg::in_item_t random_event();
		rcw_pkg::in_item_t ev;
		int unsigned pick;
		ev.rtt_sample = 24'($urandom_range(0, 24'hFFFFFF));
		ev.remote_window = 16'($urandom_range(0, 16'hFFFF));
		ev.fast_resent = 1'($urandom_range(0, 1));
		ev.loss_seen = 1'($urandom_range(0, 1));
		ev.in_flight = 16'($urandom_range(0, 16'hFFFF));
		if ($urandom_range(0, 19) == 0)
			peer_hint = $urandom_range(1, 400);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			ev.mode = rcw_pkg::MODE_SAMPLE;
			if ($urandom_range(0, 6) != 0)
				ev.rtt_sample = 24'($urandom_range(1, 3000));
		end else if (pick < 80) begin
			ev.mode = rcw_pkg::MODE_ACK;
			if ($urandom_range(0, 9) != 0)
				ev.remote_window = 16'(peer_hint);
		end else if (pick < 97) begin
			ev.mode = rcw_pkg::MODE_FLUSH;
			ev.loss_seen = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) != 0)
				ev.in_flight = 16'($urandom_range(0, 2 * peer_hint));
		end else begin
			ev.mode = MODE_UNUSED;
		end
		return ev;
	endfunction

	// Send one item; valid stays high until the block takes it.
	task automatic send_event(input rcw_pkg::in_item_t ev);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= ev;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
	endtask

	// Lower valid and wait until every sent item has produced its result.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; write enable is left high for a following write.
	task automatic write_register(input logic [rcw_pkg::CFG_IDX_W-1:0] idx,
			input logic [rcw_pkg::CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			rcw_pkg::CFG_FLUSH_INTERVAL:    cf_flush_ival = val[12:0];
			rcw_pkg::CFG_MIN_RTO:           cf_min_rto = val;
			rcw_pkg::CFG_MAX_RTO:           cf_max_rto = val;
			rcw_pkg::CFG_SEGMENT_SIZE:      cf_seg = val[13:0];
			rcw_pkg::CFG_FAST_RESEND_COUNT: cf_fast_cnt = val[7:0];
			rcw_pkg::CFG_MIN_THRESHOLD:     cf_min_thresh = val;
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [15:0] flush_ival, input logic [15:0] min_rto,
			input logic [15:0] max_rto, input logic [15:0] seg, input logic [15:0] fast_cnt,
			input logic [15:0] min_thresh);
		write_register(rcw_pkg::CFG_FLUSH_INTERVAL, flush_ival);
		write_register(rcw_pkg::CFG_MIN_RTO, min_rto);
		write_register(rcw_pkg::CFG_MAX_RTO, max_rto);
		write_register(rcw_pkg::CFG_SEGMENT_SIZE, seg);
		write_register(rcw_pkg::CFG_FAST_RESEND_COUNT, fast_cnt);
		write_register(rcw_pkg::CFG_MIN_THRESHOLD, min_thresh);
		cfg_write <= 1'b0;
		settings_written++;
	endtask

	// Reset defaults: ignored mode, first-sample rules, RTO floor, window floor, cuts.
	task automatic test_reset_defaults();
		send_event(make_event(MODE_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
		send_event(make_event(rcw_pkg::MODE_ACK, '0, 16'd0, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b0, 1'b0, 16'd0));
		send_event(make_event(rcw_pkg::MODE_SAMPLE, 24'd0, '0, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_SAMPLE, 24'd1, '0, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_SAMPLE, 24'd0, '0, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_SAMPLE, 24'hFFFFFF, '0, 1'b0, 1'b0, '0));
		repeat (3)
			send_event(make_event(rcw_pkg::MODE_ACK, '0, 16'hFFFF, 1'b0, 1'b0, '0));
		// Fast resend is disabled here, so the fast resent flag has no effect.
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b1, 1'b0, 16'd100));
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b0, 1'b1, 16'hFFFF));
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b1, 1'b1, 16'd7));
	endtask

	// Extreme settings: min_rto above max_rto, saturating window after fast resend.
	task automatic test_extreme_settings();
		wait_idle();
		write_settings(16'd10, 16'd65535, 16'd1, 16'd26, 16'd1, 16'd1);
		send_event(make_event(rcw_pkg::MODE_SAMPLE, 24'd100, '0, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b1, 1'b0, 16'hFFFF));
		send_event(make_event(rcw_pkg::MODE_ACK, '0, 16'hFFFF, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b1, 1'b0, 16'd0));
		wait_idle();
		write_settings(16'd8191, 16'd0, 16'd65535, 16'd16383, 16'd255, 16'd65535);
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b1, 1'b1, 16'hFFFF));
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b1, 1'b0, 16'd2));
		send_event(make_event(rcw_pkg::MODE_ACK, '0, 16'hFFFF, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_SAMPLE, 24'd0, '0, 1'b0, 1'b0, '0));
		send_event(make_event(rcw_pkg::MODE_SAMPLE, 24'hFFFFFF, '0, 1'b0, 1'b0, '0));
	endtask

	// A zero segment size makes the avoidance quotient zero.
	task automatic test_zero_segment();
		wait_idle();
		write_settings(16'd100, 16'd30, 16'd60000, 16'd0, 16'd3, 16'd2);
		send_event(make_event(rcw_pkg::MODE_FLUSH, '0, '0, 1'b0, 1'b1, 16'd0));
		repeat (4)
			send_event(make_event(rcw_pkg::MODE_ACK, '0, 16'd500, 1'b0, 1'b0, '0));
	endtask

	// Random traffic under a series of random settings.
	task automatic test_random_traffic();
		repeat (6) begin
			wait_idle();
			write_settings(16'($urandom_range(10, 5000)),
				16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 300)
					: $urandom_range(0, 65535)),
				16'(($urandom_range(0, 4) != 0) ? $urandom_range(1000, 65535)
					: $urandom_range(1, 500)),
				16'($urandom_range(26, 9000)),
				16'(($urandom_range(0, 3) == 0) ? 0 :
					(($urandom_range(0, 9) == 0) ? $urandom_range(9, 255)
						: $urandom_range(1, 8))),
				16'(($urandom_range(0, 6) != 0) ? $urandom_range(1, 16)
					: $urandom_range(1, 65535)));
			repeat (190)
				send_event(random_event());
		end
	endtask

	// The consumer stops for a long stretch while items keep coming.
	task automatic test_output_backpressure();
		hold_req = 1'b1;
		idle_on = 1'b0;
		repeat (30)
			send_event(random_event());
		idle_on = 1'b1;
	endtask

	// Both sides at full rate.
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (80)
			send_event(random_event());
		idle_on = 1'b1;
	endtask

	// Result consumer: random stalls per item, and one long hold on request.
	initial begin : consumer
		int w;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_LEN; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end
			w = idle_on ? $urandom_range(0, 3) : 0;
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Compare each accepted result with the oldest prediction, then predict new items.
	always @(posedge clk) begin : scoreboard
		rcw_pkg::out_item_t want;
		if (out_valid === 1'b1 && out_ready) begin
			results_seen++;
			if (exp_count == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: rto=%0d cwnd=%0d thresh=%0d",
						out_item.rto_now, out_item.cwnd_now, out_item.threshold_now);
			end else begin
				want = exp_buf[exp_head];
				exp_head = exp_head + 6'd1;
				exp_count--;
				if (out_item.rto_now !== want.rto_now || out_item.cwnd_now !== want.cwnd_now
						|| out_item.threshold_now !== want.threshold_now) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d: want %0d/%0d/%0d got %0d/%0d/%0d",
							results_seen, want.rto_now, want.cwnd_now,
							want.threshold_now, out_item.rto_now,
							out_item.cwnd_now, out_item.threshold_now);
				end
			end
		end
		if (in_valid && in_ready === 1'b1) begin
			exp_buf[exp_tail] = predict_timers(in_item);
			exp_tail = exp_tail + 6'd1;
			exp_count++;
			mode_seen[in_item.mode]++;
		end
	end

	// Watchdog on cycles with no item moving on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extreme_settings();
		test_zero_segment();
		test_random_traffic();
		test_output_backpressure();
		test_back_to_back();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		fail_count += exp_count;
		$display("Ran %0d samples, %0d acks, %0d flushes, %0d ignored under %0d settings.",
			mode_seen[rcw_pkg::MODE_SAMPLE], mode_seen[rcw_pkg::MODE_ACK],
			mode_seen[rcw_pkg::MODE_FLUSH], mode_seen[MODE_UNUSED], settings_written);
		$display("Checked %0d results, %0d failures.", results_seen, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
